// ===== sv/uvs_pkg.sv =====
// Shared types, constants and the sine table builder for the UV sphere vertex generator.
// No dependencies; every other file imports this package.
package uvs_pkg;

	// Fixed field widths of the request and vertex channels
	localparam int CELL_W   = 10;
	localparam int CFG_W    = 4;
	localparam int CORNER_W = 3;
	localparam int COORD_W  = 16;
	localparam int TEX_W    = 17;

	// Register reset and texcoord constants
	localparam logic [CFG_W-1:0] DIV_LOG2_RESET = 4'd9;
	localparam logic [CFG_W-1:0] DIV_LOG2_MIN   = 4'd1;
	localparam logic [TEX_W-1:0] TEX_ONE        = 17'h10000;
	localparam logic [4:0]       TEX_FRAC       = 5'd16;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Vertex slots within one cell: a, b, c, c, b, d
	localparam logic [CORNER_W-1:0] CRN_A  = 3'd0;
	localparam logic [CORNER_W-1:0] CRN_B  = 3'd1;
	localparam logic [CORNER_W-1:0] CRN_C  = 3'd2;
	localparam logic [CORNER_W-1:0] CRN_C2 = 3'd3;
	localparam logic [CORNER_W-1:0] CRN_B2 = 3'd4;
	localparam logic [CORNER_W-1:0] CRN_D  = 3'd5;

	typedef struct packed {
		logic [CORNER_W-1:0] corner;
		logic                last;
	} corner_tag_t;

	typedef struct packed {
		corner_tag_t      tag;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v;
	} vtx_side_t;

	// Latitude step of a corner: b and d sit one row up
	function automatic logic corner_dlat(input logic [CORNER_W-1:0] c);
		return (c inside {CRN_B, CRN_B2, CRN_D});
	endfunction

	// Longitude step of a corner: c and d sit one column over
	function automatic logic corner_dlon(input logic [CORNER_W-1:0] c);
		return (c inside {CRN_C, CRN_C2, CRN_D});
	endfunction

	// Quarter-wave sine entry k: Q30 Taylor series, rounded half up to fbits
	// fraction bits and saturated to 2^fbits - 1. Evaluated at elaboration.
	function automatic logic [31:0] sine_entry(input int k, input int mlog2, input int fbits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        r;
		logic [63:0]        top;
		logic signed [63:0] sum;
		x = (HALF_PI_Q30 * 64'(k) + (64'(1) << (mlog2 - 2))) >> (mlog2 - 1);
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x);
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd342; sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd420; sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd506; sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd600; sum = sum + signed'(term);
		if (sum < 0) begin
			sum = 0;
		end
		r = (unsigned'(sum) + (64'(1) << (29 - fbits))) >> (30 - fbits);
		top = (64'(1) << fbits) - 64'(1);
		if (r > top) begin
			r = top;
		end
		return r[31:0];
	endfunction

endpackage

// ===== sv/uvs_if.sv =====
// Channel interfaces: cell requests in, vertices out, divisions register writes.
// Depends on uvs_pkg for field widths.
interface uvs_cell_if;
	import uvs_pkg::*;
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] lat_cell;
	logic [CELL_W-1:0] lon_cell;
	modport source(output valid, lat_cell, lon_cell, input ready);
	modport sink(input valid, lat_cell, lon_cell, output ready);
endinterface

interface uvs_vertex_if;
	import uvs_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [CORNER_W-1:0]        corner;
	logic signed [COORD_W-1:0]  pos_x;
	logic signed [COORD_W-1:0]  pos_y;
	logic signed [COORD_W-1:0]  pos_z;
	logic [TEX_W-1:0]           tex_u;
	logic [TEX_W-1:0]           tex_v;
	logic                       last_corner;
	modport source(output valid, corner, pos_x, pos_y, pos_z, tex_u, tex_v, last_corner,
		input ready);
	modport sink(input valid, corner, pos_x, pos_y, pos_z, tex_u, tex_v, last_corner,
		output ready);
endinterface

interface uvs_cfg_if;
	import uvs_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ===== sv/uvs_sine_rom.sv =====
// Quarter-wave sine table, 2^(MAX_LOG2-1)+1 entries, with a registered read.
// Depends on uvs_pkg for the entry builder.
module uvs_sine_rom #(
	parameter int MAX_LOG2 = 10,
	parameter int FRAC     = 15
) (
	input  logic                clk,
	input  logic                en,
	input  logic [MAX_LOG2-1:0] addr,
	output logic [FRAC-1:0]     data_q
);
	import uvs_pkg::*;

	localparam int QS = 1 << (MAX_LOG2 - 1);

	logic [FRAC-1:0] tbl [QS+1];

	// Build the table from constants
	for (genvar k = 0; k <= QS; k++) begin : g_ent
		localparam logic [31:0] ENTRY = sine_entry(k, MAX_LOG2, FRAC);
		assign tbl[k] = ENTRY[FRAC-1:0];
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= tbl[addr];
		end
	end

endmodule

// ===== sv/uvs_seq.sv =====
// Corner sequencer: holds one cell and issues its six corners, one per cycle while req_ready is high.
// Depends on uvs_pkg and uvs_if.
module uvs_seq #(
	parameter int MAX_LOG2 = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	uvs_cell_if.sink                      grid_cell,
	input  logic [uvs_pkg::CFG_W-1:0]     n,
	output logic                          req_valid,
	input  logic                          req_ready,
	output logic [MAX_LOG2:0]             req_li,
	output logic [MAX_LOG2:0]             req_lj,
	output uvs_pkg::corner_tag_t          req_tag
);
	import uvs_pkg::*;

	logic                 busy_q;
	logic [CORNER_W-1:0]  corner_q;
	logic [MAX_LOG2-1:0]  i_q;
	logic [MAX_LOG2-1:0]  j_q;
	logic [MAX_LOG2-1:0]  mask;
	logic [MAX_LOG2+CELL_W-1:0] lat_ext;
	logic [MAX_LOG2+CELL_W-1:0] lon_ext;
	logic                 last;
	logic                 fire;
	logic                 accept;

	// Drop index bits at or above n
	assign mask    = ~({MAX_LOG2{1'b1}} << n);
	assign lat_ext = {{MAX_LOG2{1'b0}}, grid_cell.lat_cell};
	assign lon_ext = {{MAX_LOG2{1'b0}}, grid_cell.lon_cell};

	assign last            = (corner_q == CRN_D);
	assign fire            = busy_q && req_ready;
	assign grid_cell.ready = !busy_q || (last && req_ready);
	assign accept          = grid_cell.valid && grid_cell.ready;

	// Current corner request
	assign req_valid      = busy_q;
	assign req_li         = {1'b0, i_q} + (MAX_LOG2 + 1)'(corner_dlat(corner_q));
	assign req_lj         = {1'b0, j_q} + (MAX_LOG2 + 1)'(corner_dlon(corner_q));
	assign req_tag.corner = corner_q;
	assign req_tag.last   = last;

	// Advance the corner count, reload on a new cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			corner_q <= CRN_A;
		end else if (accept) begin
			busy_q   <= 1'b1;
			corner_q <= CRN_A;
		end else if (fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				corner_q <= corner_q + 3'd1;
			end
		end
	end

	// Hold the cell indices
	always_ff @(posedge clk) begin
		if (accept) begin
			i_q <= lat_ext[MAX_LOG2-1:0] & mask;
			j_q <= lon_ext[MAX_LOG2-1:0] & mask;
		end
	end

endmodule

// ===== sv/uvs_pipe.sv =====
// Six-stage vertex pipeline: phases, table addresses, table reads, products,
// signs, rounding into the output register. Depends on uvs_pkg, uvs_if, uvs_sine_rom.
module uvs_pipe #(
	parameter int MAX_LOG2 = 10,
	parameter int FRAC     = 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [uvs_pkg::CFG_W-1:0] n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [MAX_LOG2:0]         req_li,
	input  logic [MAX_LOG2:0]         req_lj,
	input  uvs_pkg::corner_tag_t      req_tag,
	uvs_vertex_if.source              vertex
);
	import uvs_pkg::*;

	localparam int PW  = MAX_LOG2 + 1;
	localparam int QS  = 1 << (MAX_LOG2 - 1);
	localparam int PRW = 2 * FRAC + 1;
	localparam int XW  = PRW + COORD_W;
	localparam int YW  = FRAC + 1 + COORD_W;
	localparam logic [PW-1:0]        QPH      = PW'(QS);
	localparam logic [MAX_LOG2-1:0]  QADR     = MAX_LOG2'(QS);
	localparam logic signed [PRW-1:0] RND_HALF = PRW'(1) << (FRAC - 1);

	// Table address of a phase; quadrants 1 and 3 read the mirror
	function automatic logic [MAX_LOG2-1:0] sin_addr(input logic [PW-1:0] p);
		logic [MAX_LOG2-1:0] r;
		r = {1'b0, p[MAX_LOG2-2:0]};
		return p[MAX_LOG2-1] ? (QADR - r) : r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6;
	vtx_side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	// Stage loads: a stage takes new data when empty or draining
	assign ld_s6     = !v_s6 || vertex.ready;
	assign ld_s5     = !v_s5 || ld_s6;
	assign ld_s4     = !v_s4 || ld_s5;
	assign ld_s3     = !v_s3 || ld_s4;
	assign ld_s2     = !v_s2 || ld_s3;
	assign ld_s1     = !v_s1 || ld_s2;
	assign req_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= req_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
			if (ld_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: phases and texcoords
	logic [3:0]       sh_lat;
	logic [3:0]       sh_lon;
	logic [4:0]       sh_tex;
	logic [PW-1:0]    lat_c_d;
	logic [PW-1:0]    lon_d;
	logic [PW-1:0]    plat_s1, plat_c_s1, plon_s1, plon_c_s1;
	vtx_side_t        side_d;

	assign sh_lat  = 4'(MAX_LOG2) - n;
	assign sh_lon  = 4'(MAX_LOG2 + 1) - n;
	assign sh_tex  = TEX_FRAC - {1'b0, n};
	assign lat_c_d = req_li << sh_lat;
	assign lon_d   = req_lj << sh_lon;

	assign side_d.tag   = req_tag;
	assign side_d.tex_u = TEX_W'(req_lj) << sh_tex;
	assign side_d.tex_v = TEX_ONE - (TEX_W'(req_li) << sh_tex);

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			plat_c_s1 <= lat_c_d;
			plat_s1   <= lat_c_d - QPH;
			plon_s1   <= lon_d;
			plon_c_s1 <= lon_d + QPH;
			side_s1   <= side_d;
		end
	end

	// Stage 2: table addresses and signs
	logic [MAX_LOG2-1:0] a_cl_s2, a_sl_s2, a_co_s2, a_so_s2;
	logic                n_cl_s2, n_sl_s2, n_co_s2, n_so_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			a_cl_s2 <= sin_addr(plat_c_s1);
			a_sl_s2 <= sin_addr(plat_s1);
			a_co_s2 <= sin_addr(plon_c_s1);
			a_so_s2 <= sin_addr(plon_s1);
			n_cl_s2 <= plat_c_s1[MAX_LOG2];
			n_sl_s2 <= plat_s1[MAX_LOG2];
			n_co_s2 <= plon_c_s1[MAX_LOG2];
			n_so_s2 <= plon_s1[MAX_LOG2];
			side_s2 <= side_s1;
		end
	end

	// Stage 3: table reads
	logic [FRAC-1:0] m_cl_s3, m_sl_s3, m_co_s3, m_so_s3;
	logic            n_cl_s3, n_sl_s3, n_co_s3, n_so_s3;

	uvs_sine_rom #(.MAX_LOG2(MAX_LOG2), .FRAC(FRAC)) u_rom_cl (
		.clk(clk), .en(ld_s3), .addr(a_cl_s2), .data_q(m_cl_s3));
	uvs_sine_rom #(.MAX_LOG2(MAX_LOG2), .FRAC(FRAC)) u_rom_sl (
		.clk(clk), .en(ld_s3), .addr(a_sl_s2), .data_q(m_sl_s3));
	uvs_sine_rom #(.MAX_LOG2(MAX_LOG2), .FRAC(FRAC)) u_rom_co (
		.clk(clk), .en(ld_s3), .addr(a_co_s2), .data_q(m_co_s3));
	uvs_sine_rom #(.MAX_LOG2(MAX_LOG2), .FRAC(FRAC)) u_rom_so (
		.clk(clk), .en(ld_s3), .addr(a_so_s2), .data_q(m_so_s3));

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			n_cl_s3 <= n_cl_s2;
			n_sl_s3 <= n_sl_s2;
			n_co_s3 <= n_co_s2;
			n_so_s3 <= n_so_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: magnitude products
	logic [2*FRAC-1:0] prod_x_s4, prod_z_s4;
	logic              n_x_s4, n_z_s4, n_y_s4;
	logic [FRAC-1:0]   m_y_s4;

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			prod_x_s4 <= m_cl_s3 * m_co_s3;
			prod_z_s4 <= m_cl_s3 * m_so_s3;
			n_x_s4    <= n_cl_s3 ^ n_co_s3;
			n_z_s4    <= n_cl_s3 ^ n_so_s3;
			m_y_s4    <= m_sl_s3;
			n_y_s4    <= n_sl_s3;
			side_s4   <= side_s3;
		end
	end

	// Stage 5: apply signs
	logic signed [PRW-1:0]  p_x_s5, p_z_s5;
	logic signed [FRAC:0]   y_s5;
	logic [PRW-1:0]         px_mag, pz_mag;
	logic [FRAC:0]          y_mag;

	assign px_mag = {1'b0, prod_x_s4};
	assign pz_mag = {1'b0, prod_z_s4};
	assign y_mag  = {1'b0, m_y_s4};

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			p_x_s5  <= n_x_s4 ? -signed'(px_mag) : signed'(px_mag);
			p_z_s5  <= n_z_s4 ? -signed'(pz_mag) : signed'(pz_mag);
			y_s5    <= n_y_s4 ? -signed'(y_mag) : signed'(y_mag);
			side_s5 <= side_s4;
		end
	end

	// Stage 6: round half up and fit to the output field
	logic signed [PRW-1:0] rx_t, rz_t;
	logic signed [XW-1:0]  rx_e, rz_e, rx_sh, rz_sh;
	logic signed [YW-1:0]  y_e;
	logic signed [COORD_W-1:0] pos_x_s6, pos_y_s6, pos_z_s6;

	assign rx_t  = p_x_s5 + RND_HALF;
	assign rz_t  = p_z_s5 + RND_HALF;
	assign rx_e  = XW'(rx_t);
	assign rz_e  = XW'(rz_t);
	assign rx_sh = rx_e >>> FRAC;
	assign rz_sh = rz_e >>> FRAC;
	assign y_e   = YW'(y_s5);

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			pos_x_s6 <= rx_sh[COORD_W-1:0];
			pos_z_s6 <= rz_sh[COORD_W-1:0];
			pos_y_s6 <= y_e[COORD_W-1:0];
			side_s6  <= side_s5;
		end
	end

	// Output register drives the vertex channel
	assign vertex.valid       = v_s6;
	assign vertex.corner      = side_s6.tag.corner;
	assign vertex.last_corner = side_s6.tag.last;
	assign vertex.pos_x       = pos_x_s6;
	assign vertex.pos_y       = pos_y_s6;
	assign vertex.pos_z       = pos_z_s6;
	assign vertex.tex_u       = side_s6.tex_u;
	assign vertex.tex_v       = side_s6.tex_v;

endmodule

// ===== sv/uv_sphere_vertex_generator_top.sv =====
// UV sphere vertex generator: six vertices (a, b, c, c, b, d) per latitude/longitude cell.
// Throughput: one vertex per cycle while the vertex channel is ready, set by the corner sequencer
// feeding the single vertex channel; a new cell is taken as the sixth corner issues.
// Reset: clears all valid bits and the sequencer, divisions_log2 returns to 9.
// The sine table is constant logic and needs no fill after reset.
module uv_sphere_vertex_generator_top #(
	parameter int MAX_DIVISIONS_LOG2  = 10,
	parameter int COORD_FRACTION_BITS = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	uvs_cfg_if.sink      cfg,
	uvs_cell_if.sink     grid_cell,
	uvs_vertex_if.source vertex
);
	import uvs_pkg::*;

	logic [CFG_W-1:0]          div_log2_q;
	logic [CFG_W-1:0]          n_eff;
	logic                      req_valid;
	logic                      req_ready;
	logic [MAX_DIVISIONS_LOG2:0] req_li;
	logic [MAX_DIVISIONS_LOG2:0] req_lj;
	corner_tag_t               req_tag;

	// Register write; always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_log2_q <= DIV_LOG2_RESET;
		end else if (cfg.valid) begin
			div_log2_q <= cfg.data;
		end
	end

	// Saturate divisions to the supported range
	always_comb begin
		if (div_log2_q < DIV_LOG2_MIN) begin
			n_eff = DIV_LOG2_MIN;
		end else if (div_log2_q > CFG_W'(MAX_DIVISIONS_LOG2)) begin
			n_eff = CFG_W'(MAX_DIVISIONS_LOG2);
		end else begin
			n_eff = div_log2_q;
		end
	end

	uvs_seq #(.MAX_LOG2(MAX_DIVISIONS_LOG2)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_cell (grid_cell),
		.n         (n_eff),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_li    (req_li),
		.req_lj    (req_lj),
		.req_tag   (req_tag)
	);

	uvs_pipe #(.MAX_LOG2(MAX_DIVISIONS_LOG2), .FRAC(COORD_FRACTION_BITS)) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n_eff),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_li    (req_li),
		.req_lj    (req_lj),
		.req_tag   (req_tag),
		.vertex    (vertex)
	);

	// Last-corner flag marks exactly slot d
	a_last_is_d: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid |-> ((vertex.corner == CRN_D) == vertex.last_corner))
		else $error("last_corner does not match corner d");

	// A cell is taken only when no corner of the previous cell is left to issue
	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		(grid_cell.valid && grid_cell.ready) |-> (!req_valid || (req_ready && req_tag.last)))
		else $error("cell request taken while corners pending");

	// Corners issue back to back in order within a cell
	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && !req_tag.last) |=>
		(req_valid && (req_tag.corner == $past(req_tag.corner) + 3'd1)))
		else $error("corner sequence broken");

endmodule

// ===== tb/sv/tb_uv_sphere_vertex_generator_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for uv_sphere_vertex_generator_top: offers grid cells, predicts the six
// vertices of each cell from a locally built sine table and checks every vertex in order.
// Depends on uvs_pkg, the channel interfaces in uvs_if.sv and the top-level RTL.
module tb_uv_sphere_vertex_generator_top;
	import uvs_pkg::*;

	localparam int MAX_DIV_LOG2     = 10;
	localparam int FRAC_BITS        = 15;
	localparam int QUARTER          = 1 << (MAX_DIV_LOG2 - 1);
	localparam int PHASE_BITS       = MAX_DIV_LOG2 + 1;
	localparam int COORD_TOP        = (1 << FRAC_BITS) - 1;
	localparam int CORNERS_PER_CELL = 6;
	localparam int SETTLE_CYCLES    = 20;
	localparam int LONG_HOLD        = 300;
	localparam int DIR_N            = 20;
	localparam int RAND_PHASES      = 8;
	localparam int PHASE_ITEMS      = 25;
	localparam logic [CFG_W-1:0] DIV_MAX = 4'd10;

	// Values that can be read straight off the sphere: poles and the equator
	localparam logic signed [COORD_W-1:0] SOUTH_Y   = -COORD_TOP;
	localparam logic signed [COORD_W-1:0] EQUATOR_X = 16'sd32766;  // 32767^2 rounded to Q1.15
	localparam logic [TEX_W-1:0]          TEX_HALF  = TEX_ONE >> 1;

	typedef struct {
		logic [CORNER_W-1:0]       corner;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [TEX_W-1:0]          tex_u;
		logic [TEX_W-1:0]          tex_v;
		logic                      last;
	} vertex_t;

	// One directed request; when pinned, corner a is checked against the typed values
	typedef struct {
		logic [CFG_W-1:0]          div;
		logic [CELL_W-1:0]         lat;
		logic [CELL_W-1:0]         lon;
		bit                        pinned;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [TEX_W-1:0]          u;
		logic [TEX_W-1:0]          v;
	} cell_row_t;

	logic clk = 1'b0;
	logic arst_n;

	uvs_cfg_if    cfg_ch();
	uvs_cell_if   cell_ch();
	uvs_vertex_if vtx_ch();

	uv_sphere_vertex_generator_top #(
		.MAX_DIVISIONS_LOG2(MAX_DIV_LOG2),
		.COORD_FRACTION_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.grid_cell(cell_ch),
		.vertex(vtx_ch)
	);

	int               sine_tab [0:QUARTER];
	vertex_t          vertex_q [$];
	logic [CFG_W-1:0] div_log2 = DIV_LOG2_RESET;
	int               errors = 0;
	int               cells_taken = 0;
	int               vertices_seen = 0;
	int               div_writes = 0;
	int               idle_pct = 20;
	int               stall_left = 0;
	bit               long_hold_req = 1'b0;
	bit               pin_on = 1'b0;
	vertex_t          pin_vtx;
	cell_row_t        dir_tab [0:DIR_N-1];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Taylor series of sin(x) in Q30, x in [0, pi/2]
	function automatic longint taylor_sine_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned div_k;
		longint          sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 12; k++) begin
			div_k = (2 * k) * (2 * k + 1);
			term = ((term * x2) >> 30) / div_k;
			if (k % 2) begin
				sum -= longint'(term);
			end else begin
				sum += longint'(term);
			end
		end
		return (sum < 0) ? 0 : sum;
	endfunction

	// Fill the quarter-wave table, rounded half up and saturated at the top
	function automatic void build_sine_tab();
		longint unsigned x;
		longint          s;
		longint          r;
		for (int k = 0; k <= QUARTER; k++) begin
			x = (HALF_PI_Q30 * k + (QUARTER >> 1)) >> (MAX_DIV_LOG2 - 1);
			s = taylor_sine_q30(x);
			r = (s + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
			if (r > COORD_TOP) begin
				r = COORD_TOP;
			end
			sine_tab[k] = int'(r);
		end
	endfunction

	function automatic int phase_sine(input logic [31:0] p);
		logic [PHASE_BITS-1:0] ph;
		logic [1:0]            quad;
		int                    r;
		ph = p[PHASE_BITS-1:0];
		quad = ph[PHASE_BITS-1 -: 2];
		r = int'(ph[MAX_DIV_LOG2-2:0]);
		case (quad)
			2'd0: return sine_tab[r];
			2'd1: return sine_tab[QUARTER - r];
			2'd2: return -sine_tab[r];
			default: return -sine_tab[QUARTER - r];
		endcase
	endfunction

	function automatic int phase_cosine(input logic [31:0] p);
		return phase_sine(p + QUARTER);
	endfunction

	// Product of two Q1.15 values, rounded half up back to Q1.15
	function automatic int round_product(input int a, input int b);
		longint prod;
		longint t;
		prod = longint'(a) * longint'(b);
		t = prod + (longint'(1) << (2 * FRAC_BITS + 1)) + (longint'(1) << (FRAC_BITS - 1));
		return int'((t >>> FRAC_BITS) - (longint'(1) << (FRAC_BITS + 1)));
	endfunction

	// Saturate the register to the supported range of divisions
	function automatic int clamped_divisions(input logic [CFG_W-1:0] div);
		int n;
		n = int'(div);
		if (n < int'(DIV_LOG2_MIN)) begin
			n = int'(DIV_LOG2_MIN);
		end
		if (n > MAX_DIV_LOG2) begin
			n = MAX_DIV_LOG2;
		end
		return n;
	endfunction

	// Queue the six vertices of one cell in the order a, b, c, c, b, d
	function automatic void predict_cell(input logic [CELL_W-1:0] lat, input logic [CELL_W-1:0] lon,
			input logic [CFG_W-1:0] div);
		int          n;
		int          mask;
		int          li;
		int          lj;
		int          cos_lat;
		logic [31:0] plat;
		logic [31:0] plon;
		vertex_t     v;
		n = clamped_divisions(div);
		mask = (1 << n) - 1;
		for (int c = 0; c < CORNERS_PER_CELL; c++) begin
			v.corner = c[CORNER_W-1:0];
			li = int'(lat) & mask;
			lj = int'(lon) & mask;
			case (v.corner)
				CRN_B, CRN_B2: li++;
				CRN_C, CRN_C2: lj++;
				CRN_D: begin
					li++;
					lj++;
				end
				default: ;
			endcase
			plat = (li << (MAX_DIV_LOG2 - n)) - QUARTER;
			plon = lj << (MAX_DIV_LOG2 + 1 - n);
			cos_lat = phase_cosine(plat);
			v.pos_x = COORD_W'(round_product(cos_lat, phase_cosine(plon)));
			v.pos_y = COORD_W'(phase_sine(plat));
			v.pos_z = COORD_W'(round_product(cos_lat, phase_sine(plon)));
			// Last column keeps u at 1.0 even though the position wraps
			v.tex_u = TEX_W'(lj << (int'(TEX_FRAC) - n));
			v.tex_v = TEX_W'(int'(TEX_ONE) - (li << (int'(TEX_FRAC) - n)));
			v.last = (v.corner == CRN_D);
			vertex_q.push_back(v);
		end
	endfunction

	task automatic check_field(input string name, input logic [CORNER_W-1:0] corner,
			input logic signed [31:0] want, input logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: corner %0d %s expected %0d actual %0d", $time, corner, name, want, got);
			errors++;
		end
	endtask

	// Predict on every accepted request, check every accepted vertex
	always @(posedge clk) begin
		vertex_t got;
		vertex_t want;
		if (arst_n) begin
			if (cell_ch.valid && cell_ch.ready) begin
				predict_cell(cell_ch.lat_cell, cell_ch.lon_cell, div_log2);
				if (pin_on) begin
					vertex_q[vertex_q.size() - CORNERS_PER_CELL] = pin_vtx;
				end
				cells_taken++;
			end
			if (vtx_ch.valid && vtx_ch.ready) begin
				got.corner = vtx_ch.corner;
				got.pos_x = vtx_ch.pos_x;
				got.pos_y = vtx_ch.pos_y;
				got.pos_z = vtx_ch.pos_z;
				got.tex_u = vtx_ch.tex_u;
				got.tex_v = vtx_ch.tex_v;
				got.last = vtx_ch.last_corner;
				vertices_seen++;
				if (vertex_q.size() == 0) begin
					$display("%0t: vertex with no request pending, expected none actual corner %0d",
						$time, got.corner);
					errors++;
				end else begin
					want = vertex_q.pop_front();
					check_field("corner", want.corner, want.corner, got.corner);
					check_field("pos_x", want.corner, want.pos_x, got.pos_x);
					check_field("pos_y", want.corner, want.pos_y, got.pos_y);
					check_field("pos_z", want.corner, want.pos_z, got.pos_z);
					check_field("tex_u", want.corner, want.tex_u, got.tex_u);
					check_field("tex_v", want.corner, want.tex_v, got.tex_v);
					check_field("last_corner", want.corner, want.last, got.last);
				end
			end
		end
	end

	// Vertex receiver: random stall bursts, plus one long hold on demand
	initial begin
		vtx_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				vtx_ch.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				vtx_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 17);
				vtx_ch.ready <= 1'b0;
			end else begin
				vtx_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one request and return on the falling edge after it is taken
	task automatic offer_cell(input logic [CELL_W-1:0] lat, input logic [CELL_W-1:0] lon);
		cell_ch.valid <= 1'b1;
		cell_ch.lat_cell <= lat;
		cell_ch.lon_cell <= lon;
		@(posedge clk);
		while (!cell_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic cell_gap();
		if ($urandom_range(0, 99) < idle_pct) begin
			cell_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
	endtask

	// Drop valid and hold until every predicted vertex is back, then let the pipe settle
	task automatic wait_drained();
		cell_ch.valid <= 1'b0;
		while (vertex_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_divisions(input logic [CFG_W-1:0] val);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		div_log2 = val;
		div_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stimulus: directed table, then random phases over several register settings
	initial begin
		cell_row_t         row;
		int                cnt_mask;
		int                pick;
		logic [CELL_W-1:0] lat;
		logic [CELL_W-1:0] lon;
		logic [CFG_W-1:0]  setting;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		cell_ch.valid = 1'b0;
		cell_ch.lat_cell = '0;
		cell_ch.lon_cell = '0;
		build_sine_tab();
		dir_tab = '{
			// reset setting: south pole, last column, equator, over-wide index
			'{4'd9, 10'd0, 10'd0, 1'b1, 16'sd0, SOUTH_Y, 16'sd0, 17'd0, TEX_ONE},
			'{4'd9, 10'd0, 10'd511, 1'b1, 16'sd0, SOUTH_Y, 16'sd0, 17'd65408, TEX_ONE},
			'{4'd9, 10'd256, 10'd0, 1'b1, EQUATOR_X, 16'sd0, 16'sd0, 17'd0, TEX_HALF},
			'{4'd9, 10'd512, 10'd5, 1'b1, 16'sd0, SOUTH_Y, 16'sd0, 17'd640, TEX_ONE},
			'{4'd9, 10'd1023, 10'd1023, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			'{4'd9, 10'd256, 10'd511, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			'{4'd9, 10'd300, 10'd100, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			'{4'd9, 10'd128, 10'd384, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			// coarsest grid
			'{4'd1, 10'd0, 10'd0, 1'b1, 16'sd0, SOUTH_Y, 16'sd0, 17'd0, TEX_ONE},
			'{4'd1, 10'd1, 10'd1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			'{4'd1, 10'd1023, 10'd1022, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			// zero divisions saturates up to one
			'{4'd0, 10'd0, 10'd1, 1'b1, 16'sd0, SOUTH_Y, 16'sd0, TEX_HALF, TEX_ONE},
			'{4'd0, 10'd1, 10'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			// finest grid
			'{4'd10, 10'd512, 10'd0, 1'b1, EQUATOR_X, 16'sd0, 16'sd0, 17'd0, TEX_HALF},
			'{4'd10, 10'd1023, 10'd1023, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			'{4'd10, 10'd0, 10'd1023, 1'b1, 16'sd0, SOUTH_Y, 16'sd0, 17'd65472, TEX_ONE},
			'{4'd10, 10'd341, 10'd682, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			// above the maximum saturates down to it
			'{4'd15, 10'd0, 10'd1023, 1'b1, 16'sd0, SOUTH_Y, 16'sd0, 17'd65472, TEX_ONE},
			'{4'd15, 10'd1023, 10'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0},
			'{4'd11, 10'd511, 10'd255, 1'b0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0}
		};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		for (int r = 0; r < DIR_N; r++) begin
			row = dir_tab[r];
			if (row.div != div_log2) begin
				write_divisions(row.div);
			end
			pin_vtx = '{CRN_A, row.x, row.y, row.z, row.u, row.v, 1'b0};
			pin_on = row.pinned;
			offer_cell(row.lat, row.lon);
			pin_on = 1'b0;
			cell_gap();
		end

		// Random phases; phase 3 carries the long output hold, the last one runs flat out
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: setting = DIV_LOG2_MIN;
				1: setting = DIV_MAX;
				2: setting = '0;
				3: setting = '1;
				4: setting = 4'd4;
				default: setting = CFG_W'($urandom_range(0, 15));
			endcase
			write_divisions(setting);
			if (p == 3 || p == RAND_PHASES - 1) begin
				idle_pct = 0;
			end else begin
				idle_pct = 10 * $urandom_range(0, 3);
			end
			if (p == 3) begin
				long_hold_req = 1'b1;
			end
			cnt_mask = (1 << clamped_divisions(setting)) - 1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				lat = CELL_W'($urandom);
				lon = CELL_W'($urandom);
				pick = $urandom_range(0, 9);
				case (pick)
					6: lat = (k % 2) ? CELL_W'(cnt_mask) : '0;
					7: lon = CELL_W'(cnt_mask);
					8: begin
						lat = '1;
						lon = '1;
					end
					9: lat = CELL_W'(cnt_mask);
					default: ;
				endcase
				offer_cell(lat, lon);
				if (p == 2 && k == PHASE_ITEMS / 2) begin
					wait_drained();
				end else begin
					cell_gap();
				end
			end
		end

		wait_drained();
		$display("run covered %0d cells, %0d vertices, %0d divisions writes incl. 0, 1, 10, 15",
			cells_taken, vertices_seen, div_writes);
		$display("with stall bursts on both sides, one long output hold and one input drain pause");
		if (errors == 0 && vertex_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Give up well past the slowest legal run
	initial begin
		#1000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
